// ----- rtl/gsa_pkg.sv -----
// Package for the generational slot allocator.
// Holds request and status codes, the sequencer state type and the
// free-bit search helper. No dependencies.
package gsa_pkg;

    localparam int WORD_W   = 64;
    localparam int WORD_LOG = 6;
    localparam int GEN_W    = 16;
    localparam int LIVE_W   = 7;
    localparam int IDX_W    = 6;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_LIMIT = 3'd2,
        ST_DEAD  = 3'd3,
        ST_GEN   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    // Lowest zero bit of w at or above start: {found, position}.
    function automatic logic [WORD_LOG:0] find_zero(
        input logic [WORD_W-1:0]   w,
        input logic [WORD_LOG-1:0] start
    );
        logic [WORD_W-1:0]   m;
        logic [WORD_LOG:0]   r;
        m = ~w & ({WORD_W{1'b1}} << start);
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = {1'b1, WORD_LOG'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/gsa_store.sv -----
// Slot store: generation memory (one entry per slot) and alive-bit memory
// (one 64-bit word per 64 slots), both with registered reads.
// Runs a clearing pass after reset. Depends on gsa_pkg.
module gsa_store
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [$clog2(SLOTS)-1:0] rd_slot,
    input  logic [((SLOTS + WORD_W - 1) / WORD_W > 1 ?
                   $clog2((SLOTS + WORD_W - 1) / WORD_W) : 1) - 1:0] rd_word,
    output logic [GEN_W-1:0]  gen_rdata,
    output logic [WORD_W-1:0] word_rdata,
    input  logic              wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_slot,
    input  logic [GEN_W-1:0]  wr_gen,
    input  logic [WORD_W-1:0] wr_word,
    output logic              busy
);

    localparam int SW     = $clog2(SLOTS);
    localparam int NWORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WA_W   = NWORDS > 1 ? $clog2(NWORDS) : 1;

    logic [GEN_W-1:0]  gen_mem  [0:SLOTS-1];
    logic [WORD_W-1:0] word_mem [0:NWORDS-1];

    logic [SW-1:0] clr_reg, clr_next;
    logic          busy_reg, busy_next;
    logic [WA_W-1:0] wr_word_addr;

    assign wr_word_addr = WA_W'(wr_slot >> WORD_LOG);
    assign busy = busy_reg;

    always_comb
    begin
        clr_next  = clr_reg + SW'(1);
        busy_next = busy_reg && (clr_reg != SW'(SLOTS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            gen_mem[clr_reg] <= '0;
            if (clr_reg < SW'(NWORDS))
            begin
                word_mem[clr_reg[WA_W-1:0]] <= '0;
            end
        end
        else if (wr_en)
        begin
            gen_mem[wr_slot]       <= wr_gen;
            word_mem[wr_word_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_rdata  <= gen_mem[rd_slot];
        word_rdata <= word_mem[rd_word];
    end

endmodule

// ----- rtl/generational_slot_allocator.sv -----
// Generational slot allocator, top level.
// Sequencer around gsa_store; holds next-free pointer, live count, limit.
// Depends on gsa_pkg and gsa_store.
//
// Usage:
//   Requests enter on in_valid/in_ready with req_type, slot_index and
//   generation_in; one result item leaves on out_valid/out_ready with ok,
//   status, slot_out, generation_out and live_count_out.
//   max_live is written through cfg_wr_en/cfg_wr_data; the user must write
//   it only while idle, as the block does not enforce this. An accepted item
//   goes through the execute state, any scan states and the response state,
//   which loads the result into the output register; a new item is taken only
//   in the idle state. A successful allocate scans further 64-slot alive words
//   to find the next free slot. The search and the generation read-modify-write
//   go through the store, one alive word per cycle. Reset: a clearing pass
//   zeroes the store; in_ready stays low until it ends. max_live resets to 64.
//   A stalled result sits in the output register; the next item is still
//   taken and waits in the response state until the output is free.
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [IDX_W-1:0]  slot_index,
    input  logic [GEN_W-1:0]  generation_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [2:0]        status,
    output logic [IDX_W-1:0]  slot_out,
    output logic [GEN_W-1:0]  generation_out,
    output logic [LIVE_W-1:0] live_count_out,
    input  logic              cfg_wr_en,
    input  logic [LIVE_W-1:0] cfg_wr_data
);

    localparam int SW     = $clog2(SLOTS);
    localparam int NF_W   = $clog2(SLOTS + 1);
    localparam int PW     = NF_W + WORD_LOG;
    localparam int NWORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WA_W   = NWORDS > 1 ? $clog2(NWORDS) : 1;

    state_t state_reg, state_next;

    logic [1:0]        req_reg;
    logic [PW-1:0]     tgt_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [GEN_W-1:0]  gin_reg;
    logic [WA_W-1:0]   scan_reg, scan_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic [LIVE_W-1:0] max_live_reg;

    logic              res_ok_reg, res_ok_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic [GEN_W-1:0]  res_gen_reg, res_gen_next;

    logic              out_valid_reg;
    logic              ok_reg;
    logic [2:0]        status_reg;
    logic [IDX_W-1:0]  slot_out_reg;
    logic [GEN_W-1:0]  gen_out_reg;
    logic [LIVE_W-1:0] live_out_reg;

    logic              busy;
    logic [GEN_W-1:0]  gen_rdata;
    logic [WORD_W-1:0] word_rdata;
    logic [SW-1:0]     rd_slot;
    logic [WA_W-1:0]   rd_word;
    logic              wr_en;
    logic [GEN_W-1:0]  wr_gen;
    logic [WORD_W-1:0] wr_word;

    logic              accept;
    logic              load_out;
    logic [PW-1:0]     tgt_in;
    logic [PW-1:0]     tgt_word;
    logic [PW-1:0]     cand;
    logic [PW-1:0]     nxt_word;
    logic [PW-1:0]     hit_pos;
    logic [WORD_LOG:0] ff;
    logic [WORD_W-1:0] bit_mask;
    logic              alive_hit;
    logic              alloc_ok;
    logic              go_scan;

    gsa_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_slot   (rd_slot),
        .rd_word   (rd_word),
        .gen_rdata (gen_rdata),
        .word_rdata(word_rdata),
        .wr_en     (wr_en),
        .wr_slot   (tgt_reg[SW-1:0]),
        .wr_gen    (wr_gen),
        .wr_word   (wr_word),
        .busy      (busy)
    );

    assign in_ready = (state_reg == S_IDLE) && !busy;
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    assign tgt_in   = (req_type == REQ_ALLOC) ? PW'(next_free_reg) : PW'(slot_index);
    assign tgt_word = tgt_reg >> WORD_LOG;
    assign cand     = tgt_reg + PW'(1);
    assign bit_mask = {{(WORD_W - 1){1'b0}}, 1'b1} << tgt_reg[WORD_LOG-1:0];
    assign alive_hit = (tgt_reg < PW'(SLOTS)) && word_rdata[tgt_reg[WORD_LOG-1:0]];
    assign alloc_ok = (live_reg < max_live_reg) && (next_free_reg < NF_W'(SLOTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = go_scan ? S_SCAN : S_RESP;
            end
            S_SCAN:
            begin
                state_next = go_scan ? S_SCAN : S_RESP;
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        rd_slot         = tgt_in[SW-1:0];
        rd_word         = WA_W'(tgt_in >> WORD_LOG);
        wr_en           = 1'b0;
        wr_gen          = gen_rdata;
        wr_word         = word_rdata;
        scan_next       = scan_reg;
        next_free_next  = next_free_reg;
        live_next       = live_reg;
        res_ok_next     = res_ok_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_gen_next    = res_gen_reg;
        go_scan         = 1'b0;
        ff              = '0;
        nxt_word        = '0;
        hit_pos         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                res_ok_next     = 1'b0;
                res_status_next = ST_OK;
                res_slot_next   = '0;
                res_gen_next    = '0;
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (live_reg >= max_live_reg)
                        begin
                            res_status_next = ST_LIMIT;
                        end
                        else if (!alloc_ok)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_gen          = gen_rdata + GEN_W'(1);
                            wr_word         = word_rdata | bit_mask;
                            live_next       = live_reg + LIVE_W'(1);
                            res_ok_next     = 1'b1;
                            res_slot_next   = tgt_reg[IDX_W-1:0];
                            res_gen_next    = gen_rdata + GEN_W'(1);
                            // search the updated word first, then later words
                            if ((cand >> WORD_LOG) == tgt_word)
                            begin
                                ff       = find_zero(word_rdata | bit_mask,
                                                     cand[WORD_LOG-1:0]);
                                nxt_word = tgt_word + PW'(1);
                            end
                            else
                            begin
                                nxt_word = cand >> WORD_LOG;
                            end
                            hit_pos = (tgt_word << WORD_LOG) | PW'(ff[WORD_LOG-1:0]);
                            if (ff[WORD_LOG])
                            begin
                                next_free_next = (hit_pos < PW'(SLOTS)) ?
                                                 NF_W'(hit_pos) : NF_W'(SLOTS);
                            end
                            else if (nxt_word >= PW'(NWORDS))
                            begin
                                next_free_next = NF_W'(SLOTS);
                            end
                            else
                            begin
                                go_scan   = 1'b1;
                                rd_word   = WA_W'(nxt_word);
                                scan_next = WA_W'(nxt_word);
                            end
                        end
                    end
                    REQ_FREE, REQ_LOOKUP:
                    begin
                        res_slot_next = idx_reg;
                        if (!alive_hit)
                        begin
                            res_status_next = ST_DEAD;
                        end
                        else if (gen_rdata != gin_reg)
                        begin
                            res_status_next = ST_GEN;
                        end
                        else
                        begin
                            res_ok_next = 1'b1;
                            if (req_reg == REQ_FREE)
                            begin
                                wr_en   = 1'b1;
                                wr_word = word_rdata & ~bit_mask;
                                if (tgt_reg < PW'(next_free_reg))
                                begin
                                    next_free_next = NF_W'(tgt_reg);
                                end
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - LIVE_W'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                ff       = find_zero(word_rdata, '0);
                hit_pos  = (PW'(scan_reg) << WORD_LOG) | PW'(ff[WORD_LOG-1:0]);
                nxt_word = PW'(scan_reg) + PW'(1);
                if (ff[WORD_LOG])
                begin
                    next_free_next = (hit_pos < PW'(SLOTS)) ?
                                     NF_W'(hit_pos) : NF_W'(SLOTS);
                end
                else if (nxt_word >= PW'(NWORDS))
                begin
                    next_free_next = NF_W'(SLOTS);
                end
                else
                begin
                    go_scan   = 1'b1;
                    rd_word   = WA_W'(nxt_word);
                    scan_next = WA_W'(nxt_word);
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            live_reg      <= '0;
            max_live_reg  <= LIVE_W'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            live_reg      <= live_next;
            if (cfg_wr_en)
            begin
                max_live_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            tgt_reg <= tgt_in;
            idx_reg <= slot_index;
            gin_reg <= generation_in;
        end
        scan_reg       <= scan_next;
        res_ok_reg     <= res_ok_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_gen_reg    <= res_gen_next;
        if (load_out)
        begin
            ok_reg       <= res_ok_reg;
            status_reg   <= res_status_reg;
            slot_out_reg <= res_slot_reg;
            gen_out_reg  <= res_gen_reg;
            live_out_reg <= live_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign status         = status_reg;
    assign slot_out       = slot_out_reg;
    assign generation_out = gen_out_reg;
    assign live_count_out = live_out_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_accept_to_exec: assert property (
        @(posedge clk) disable iff (!rst_n) accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not reach execute");

    a_next_free_range: assert property (
        @(posedge clk) disable iff (!rst_n) next_free_reg <= NF_W'(SLOTS))
        else $error("next-free pointer beyond pool");

    a_ok_status: assert property (
        @(posedge clk) disable iff (!rst_n) (out_valid_reg && ok_reg) |-> (status_reg == ST_OK))
        else $error("successful result with failure status");

endmodule
